>>> sv/bilinear_vector_field_sample_top_defines.svh
// Assertion macros shared by the block's checks.
`ifndef BILINEAR_VECTOR_FIELD_SAMPLE_TOP_DEFINES_SVH
`define BILINEAR_VECTOR_FIELD_SAMPLE_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define BVFS_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define BVFS_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> sv/bvfs_pkg.sv
`default_nettype none
package bvfs_pkg;

	localparam int FRAC_BITS = 8;
	localparam int MAX_COLS  = 64;
	localparam int MAX_ROWS  = 64;
	localparam int MIN_DIM   = 3;

	localparam int POS_W  = 14;
	localparam int CELL_W = 6;
	localparam int G_W    = 16;
	localparam int CFG_W  = 7;
	localparam int WORD_W = 2 * G_W;

	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int DEPTH  = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W = $clog2(DEPTH);

	// offset tx/ty, first-level diff, first-level lerp, second-level diff and lerp
	localparam int T_W  = POS_W + 1;
	localparam int D1_W = G_W + 1;
	localparam int L1_W = D1_W + T_W + 1;
	localparam int D2_W = L1_W + 1;
	localparam int P_W  = D2_W + T_W;
	localparam int L2_W = P_W + 1;
	localparam int SH_W = L2_W - 2 * FRAC_BITS;

	localparam int SAT_MAX = 2 ** (G_W - 1) - 1;
	localparam int SAT_MIN = -(2 ** (G_W - 1));

	localparam logic KIND_QUERY = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	localparam logic REG_GRID_COLS = 1'b0;
	localparam logic REG_GRID_ROWS = 1'b1;

	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_TOP_X = 3'd0;
	localparam logic [STEP_W-1:0] STEP_TOP_Y = 3'd1;
	localparam logic [STEP_W-1:0] STEP_BOT_X = 3'd2;
	localparam logic [STEP_W-1:0] STEP_BOT_Y = 3'd3;
	localparam logic [STEP_W-1:0] STEP_VAL_X = 3'd4;
	localparam logic [STEP_W-1:0] STEP_VAL_Y = 3'd5;

	// sequencing from the controller to the lerp unit
	typedef struct packed {
		logic              cap;
		logic [1:0]        cap_idx;
		logic              diff;
		logic              mac;
		logic [STEP_W-1:0] step;
		logic              fin;
	} lerp_ctl_t;

endpackage
`default_nettype wire

>>> sv/bilinear_vector_field_sample_top.sv
// Bilinear sampler over a 64 x 64 grid of 2D vectors. An item is taken at a
// clock edge where start is high and busy is low. A write item (kind high)
// stores one cell in that same edge and leaves busy low, so writes stream at
// one per cycle while busy is low. A query item (kind low) raises busy while
// it runs: four reads fetch the four corner cells through the single read
// port of the grid memory (plus a wait for the last read data to land), the
// six products of the two-level lerp run through one shared multiplier (a
// difference step and a multiply-accumulate step each), and a last step
// floors and saturates. The result shows on field_x, field_y and clipped for
// exactly one cycle with done high, in the cycle after busy falls; the
// receiver must take it then, as there is no way to hold it. A new item may
// be given in that same cycle; no new item is taken while a query holds busy.
// Write grid_cols and grid_rows only while no query is in flight. Cells must
// be written before any query touches them; the grid has no reset.
`default_nettype none
`include "bilinear_vector_field_sample_top_defines.svh"
module bilinear_vector_field_sample_top import bvfs_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic                     kind,
	input  wire logic [POS_W-1:0]         pos_x,
	input  wire logic [POS_W-1:0]         pos_y,
	input  wire logic [CELL_W-1:0]        cell_col,
	input  wire logic [CELL_W-1:0]        cell_row,
	input  wire logic signed [G_W-1:0]    cell_vx,
	input  wire logic signed [G_W-1:0]    cell_vy,
	input  wire logic                     cfg_we,
	input  wire logic                     cfg_idx,
	input  wire logic [CFG_W-1:0]         cfg_wdata,
	output logic                          done,
	output logic signed [G_W-1:0]         field_x,
	output logic signed [G_W-1:0]         field_y,
	output logic                          clipped
);

	logic [CFG_W-1:0] grid_cols_q, grid_rows_q;
	logic wr_acc, ram_we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [WORD_W-1:0] wdata, rdata;
	lerp_ctl_t ctl;
	logic signed [T_W-1:0] tx, ty;

	// Configuration: plain register writes, no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q <= CFG_W'(MAX_COLS);
			grid_rows_q <= CFG_W'(MAX_ROWS);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_GRID_COLS: grid_cols_q <= cfg_wdata;
				REG_GRID_ROWS: grid_rows_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Write beats go straight to the grid memory; drop any cell outside storage.
	assign wr_acc = start && !busy && (kind == KIND_WRITE);
	assign ram_we = wr_acc && (int'(cell_col) < MAX_COLS) && (int'(cell_row) < MAX_ROWS);
	assign waddr  = ADDR_W'(cell_row) * ADDR_W'(MAX_COLS) + ADDR_W'(cell_col);
	assign wdata  = {cell_vy, cell_vx};

	bvfs_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_grid (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Sequencer: clamps the base cell, walks the four corner reads and the lerp steps.
	bvfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.kind     (kind),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.grid_cols(grid_cols_q),
		.grid_rows(grid_rows_q),
		.busy     (busy),
		.raddr    (raddr),
		.ctl      (ctl),
		.tx       (tx),
		.ty       (ty)
	);

	// Shared multiply-accumulate, floor and saturate, result register.
	bvfs_lerp u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.rdata  (rdata),
		.tx     (tx),
		.ty     (ty),
		.field_x(field_x),
		.field_y(field_y),
		.clipped(clipped),
		.done   (done)
	);

	// A result beat always closes a busy stretch.
	`BVFS_ASSERT_NOW(a_done_after_busy, done, $past(busy), "result beat without a query in flight")
	// A query beat holds off new items from the next cycle.
	`BVFS_ASSERT_NEXT(a_query_busy, start && !busy && (kind == KIND_QUERY), busy, "query not held busy")
	// A write beat never starts work nor yields a result.
	`BVFS_ASSERT_NEXT(a_write_quiet, wr_acc, !busy && !done, "write beat caused work or a result")
	// The strobe lasts one cycle.
	`BVFS_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")

endmodule
`default_nettype wire

>>> sv/bvfs_ram.sv
`default_nettype none
module bvfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> sv/bvfs_ctrl.sv
`default_nettype none
module bvfs_ctrl import bvfs_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic                    kind,
	input  wire logic [POS_W-1:0]        pos_x,
	input  wire logic [POS_W-1:0]        pos_y,
	input  wire logic [CFG_W-1:0]        grid_cols,
	input  wire logic [CFG_W-1:0]        grid_rows,
	output logic                         busy,
	output logic      [ADDR_W-1:0]       raddr,
	output lerp_ctl_t                    ctl,
	output logic signed [T_W-1:0]        tx,
	output logic signed [T_W-1:0]        ty
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_READ = 5'b00010,
		S_DIFF = 5'b00100,
		S_MAC  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic [STEP_W-1:0] cnt_q, cnt_d;
	logic [COL_W-1:0] xs_q, xs_d;
	logic [ROW_W-1:0] ys_q, ys_d;
	logic signed [T_W-1:0] tx_q, ty_q, tx_d, ty_d;
	logic [CFG_W-1:0] cols_c, rows_c, fx, fy, cx, cy;
	logic [T_W-1:0] xs_sh, ys_sh;
	logic [COL_W-1:0] rd_col;
	logic [ROW_W-1:0] rd_row;
	logic q_acc;

	assign q_acc = start && (state_q == S_IDLE) && (kind == KIND_QUERY);

	// base cell and offset of the query
	always_comb begin
		cols_c = (grid_cols < CFG_W'(MIN_DIM)) ? CFG_W'(MIN_DIM) :
			(grid_cols > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : grid_cols;
		rows_c = (grid_rows < CFG_W'(MIN_DIM)) ? CFG_W'(MIN_DIM) :
			(grid_rows > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : grid_rows;
		fx = CFG_W'(pos_x >> FRAC_BITS);
		fy = CFG_W'(pos_y >> FRAC_BITS);
		cx = (fx < CFG_W'(1)) ? CFG_W'(1) : (fx > cols_c - CFG_W'(2)) ? cols_c - CFG_W'(2) : fx;
		cy = (fy < CFG_W'(1)) ? CFG_W'(1) : (fy > rows_c - CFG_W'(2)) ? rows_c - CFG_W'(2) : fy;
		xs_d = COL_W'(cx);
		ys_d = ROW_W'(cy);
		xs_sh = T_W'(xs_d) << FRAC_BITS;
		ys_sh = T_W'(ys_d) << FRAC_BITS;
		tx_d = $signed(T_W'(pos_x)) - $signed(xs_sh);
		ty_d = $signed(T_W'(pos_y)) - $signed(ys_sh);
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (q_acc) begin
					state_d = S_READ;
					cnt_d   = '0;
				end
			end
			S_READ: begin
				if (cnt_q == STEP_W'(4)) begin
					state_d = S_DIFF;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + STEP_W'(1);
				end
			end
			S_DIFF: state_d = S_MAC;
			S_MAC: begin
				if (cnt_q == STEP_VAL_Y) begin
					state_d = S_OUT;
				end else begin
					state_d = S_DIFF;
					cnt_d   = cnt_q + STEP_W'(1);
				end
			end
			S_OUT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (q_acc) begin
			xs_q <= xs_d;
			ys_q <= ys_d;
			tx_q <= tx_d;
			ty_q <= ty_d;
		end
	end

	// corner order: base, right, below, below right
	assign rd_col = xs_q + COL_W'(cnt_q[0]);
	assign rd_row = ys_q + ROW_W'(cnt_q[1]);
	assign raddr  = ADDR_W'(rd_row) * ADDR_W'(MAX_COLS) + ADDR_W'(rd_col);

	always_comb begin
		ctl.cap     = (state_q == S_READ) && (cnt_q != '0);
		ctl.cap_idx = cnt_q[1:0] - 2'd1;
		ctl.diff    = (state_q == S_DIFF);
		ctl.mac     = (state_q == S_MAC);
		ctl.step    = cnt_q;
		ctl.fin     = (state_q == S_OUT);
	end

	assign busy = (state_q != S_IDLE);
	assign tx   = tx_q;
	assign ty   = ty_q;

endmodule
`default_nettype wire

>>> sv/bvfs_lerp.sv
`default_nettype none
module bvfs_lerp import bvfs_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire lerp_ctl_t               ctl,
	input  wire logic [WORD_W-1:0]       rdata,
	input  wire logic signed [T_W-1:0]   tx,
	input  wire logic signed [T_W-1:0]   ty,
	output logic signed [G_W-1:0]        field_x,
	output logic signed [G_W-1:0]        field_y,
	output logic                         clipped,
	output logic                         done
);

	logic [WORD_W-1:0] g_q [4];
	logic signed [L1_W-1:0] top_x_q, top_y_q, bot_x_q, bot_y_q;
	logic signed [L2_W-1:0] val_x_q, val_y_q;
	logic signed [L1_W-1:0] base_d, other_d, base_q;
	logic signed [D2_W-1:0] diff_q;
	logic signed [T_W-1:0] t_d, t_q;
	logic signed [P_W-1:0] prod;
	logic signed [L2_W-1:0] acc;
	logic [G_W:0] sat_x, sat_y;
	logic signed [G_W-1:0] field_x_q, field_y_q;
	logic clipped_q, done_q;

	function automatic logic signed [L1_W-1:0] lo16(input logic [WORD_W-1:0] w);
		return L1_W'($signed(w[G_W-1:0]));
	endfunction

	function automatic logic signed [L1_W-1:0] hi16(input logic [WORD_W-1:0] w);
		return L1_W'($signed(w[WORD_W-1:G_W]));
	endfunction

	// floor by the two fraction scalings, then clip to 16 bits; msb is the clip flag
	function automatic logic [G_W:0] sat16(input logic signed [L2_W-1:0] v);
		logic signed [SH_W-1:0] s;
		logic [G_W:0] r;
		s = SH_W'(v >>> (2 * FRAC_BITS));
		if (s > $signed(SH_W'(SAT_MAX))) begin
			r = {1'b1, G_W'(SAT_MAX)};
		end else if (s < $signed(SH_W'(SAT_MIN))) begin
			r = {1'b1, G_W'(SAT_MIN)};
		end else begin
			r = {1'b0, s[G_W-1:0]};
		end
		return r;
	endfunction

	always_comb begin
		case (ctl.step)
			STEP_TOP_X: begin base_d = lo16(g_q[0]); other_d = lo16(g_q[1]); t_d = tx; end
			STEP_TOP_Y: begin base_d = hi16(g_q[0]); other_d = hi16(g_q[1]); t_d = tx; end
			STEP_BOT_X: begin base_d = lo16(g_q[2]); other_d = lo16(g_q[3]); t_d = tx; end
			STEP_BOT_Y: begin base_d = hi16(g_q[2]); other_d = hi16(g_q[3]); t_d = tx; end
			STEP_VAL_X: begin base_d = top_x_q; other_d = bot_x_q; t_d = ty; end
			STEP_VAL_Y: begin base_d = top_y_q; other_d = bot_y_q; t_d = ty; end
			default: begin base_d = '0; other_d = '0; t_d = '0; end
		endcase
	end

	assign prod = diff_q * t_q;
	assign acc  = (L2_W'(base_q) <<< FRAC_BITS) + L2_W'(prod);
	assign sat_x = sat16(val_x_q);
	assign sat_y = sat16(val_y_q);

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			g_q[ctl.cap_idx] <= rdata;
		end
		if (ctl.diff) begin
			base_q <= base_d;
			diff_q <= D2_W'(other_d) - D2_W'(base_d);
			t_q    <= t_d;
		end
		if (ctl.mac) begin
			case (ctl.step)
				STEP_TOP_X: top_x_q <= L1_W'(acc);
				STEP_TOP_Y: top_y_q <= L1_W'(acc);
				STEP_BOT_X: bot_x_q <= L1_W'(acc);
				STEP_BOT_Y: bot_y_q <= L1_W'(acc);
				STEP_VAL_X: val_x_q <= acc;
				STEP_VAL_Y: val_y_q <= acc;
				default: ;
			endcase
		end
		if (ctl.fin) begin
			field_x_q <= sat_x[G_W-1:0];
			field_y_q <= sat_y[G_W-1:0];
			clipped_q <= sat_x[G_W] | sat_y[G_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.fin;
		end
	end

	assign field_x = field_x_q;
	assign field_y = field_y_q;
	assign clipped = clipped_q;
	assign done    = done_q;

endmodule
`default_nettype wire

>>> sim/bilinear_vector_field_sample_top_test.sv
module bilinear_vector_field_sample_top_test;
	import bvfs_pkg::*;

	// A query holds busy while it runs and shows its sample in the cycle after
	// its last busy one; give it some margin before touching the size registers or ending.
	localparam int SETTLE_CYCLES = 24;
	// Longest correct stretch without a beat is a sender gap, a full query
	// and a settle pause back to back, far below this limit.
	localparam int QUIET_LIMIT   = 2000;
	localparam int PHASES        = 8;
	localparam int PHASE_BEATS   = 135;
	localparam int MAX_REPORTS   = 50;
	localparam int DIR_ROWS      = 19;

	typedef struct packed {
		logic                    kind;
		logic [POS_W-1:0]        px;
		logic [POS_W-1:0]        py;
		logic [CELL_W-1:0]       col;
		logic [CELL_W-1:0]       row;
		logic signed [G_W-1:0]   vx;
		logic signed [G_W-1:0]   vy;
	} beat_t;

	typedef struct packed {
		logic signed [G_W-1:0]   fx;
		logic signed [G_W-1:0]   fy;
		logic                    clip;
	} sample_t;

	// One row of the directed table. Where known is set the sample is typed
	// in by hand; every other query row goes through the predictor.
	typedef struct packed {
		logic                    known;
		logic                    kind;
		logic [POS_W-1:0]        px;
		logic [POS_W-1:0]        py;
		logic [CELL_W-1:0]       col;
		logic [CELL_W-1:0]       row;
		logic signed [G_W-1:0]   vx;
		logic signed [G_W-1:0]   vy;
		logic signed [G_W-1:0]   fx;
		logic signed [G_W-1:0]   fy;
		logic                    clip;
	} dir_row_t;

	// Positions are in grid units with 8 fraction bits: 256 is cell 1.0.
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		// constant patch of extreme vectors around cell (1,1); pos is junk
		'{1'b0, KIND_WRITE, 14'd16383, 14'd16383, 6'd1, 6'd1,
			16'sh7FFF, 16'sh8000, 16'sh0, 16'sh0, 1'b0},
		'{1'b0, KIND_WRITE, 14'd16383, 14'd0, 6'd2, 6'd1,
			16'sh7FFF, 16'sh8000, 16'sh0, 16'sh0, 1'b0},
		'{1'b0, KIND_WRITE, 14'd0, 14'd16383, 6'd1, 6'd2,
			16'sh7FFF, 16'sh8000, 16'sh0, 16'sh0, 1'b0},
		'{1'b0, KIND_WRITE, 14'd0, 14'd0, 6'd2, 6'd2,
			16'sh7FFF, 16'sh8000, 16'sh0, 16'sh0, 1'b0},
		// exactly on the base cell; cell fields are junk and must be ignored
		'{1'b1, KIND_QUERY, 14'd256, 14'd256, 6'd63, 6'd63,
			16'shFFFF, 16'shFFFF, 16'sh7FFF, 16'sh8000, 1'b0},
		// origin clamps to cell 1 and extrapolates, but the patch is flat
		'{1'b1, KIND_QUERY, 14'd0, 14'd0, 6'd0, 6'd0,
			16'sh0, 16'sh0, 16'sh7FFF, 16'sh8000, 1'b0},
		// flip the right neighbor so extrapolation to the left overshoots
		'{1'b0, KIND_WRITE, 14'd0, 14'd0, 6'd2, 6'd1,
			16'sh8000, 16'sh7FFF, 16'sh0, 16'sh0, 1'b0},
		'{1'b1, KIND_QUERY, 14'd0, 14'd256, 6'd0, 6'd0,
			16'sh0, 16'sh0, 16'sh7FFF, 16'sh8000, 1'b1},
		'{1'b0, KIND_QUERY, 14'd383, 14'd300, 6'd21, 6'd42,
			16'sh5555, 16'shAAAA, 16'sh0, 16'sh0, 1'b0},
		'{1'b0, KIND_QUERY, 14'd511, 14'd511, 6'd0, 6'd0,
			16'sh0, 16'sh0, 16'sh0, 16'sh0, 1'b0},
		// far corner of the largest grid
		'{1'b0, KIND_WRITE, 14'd0, 14'd0, 6'd62, 6'd62,
			16'sh0001, 16'shFFFF, 16'sh0, 16'sh0, 1'b0},
		'{1'b0, KIND_WRITE, 14'd0, 14'd0, 6'd63, 6'd62,
			16'sh8000, 16'sh7FFF, 16'sh0, 16'sh0, 1'b0},
		'{1'b0, KIND_WRITE, 14'd0, 14'd0, 6'd62, 6'd63,
			16'sh7FFF, 16'sh0000, 16'sh0, 16'sh0, 1'b0},
		'{1'b0, KIND_WRITE, 14'd0, 14'd0, 6'd63, 6'd63,
			16'sh1234, 16'sh8001, 16'sh0, 16'sh0, 1'b0},
		'{1'b0, KIND_QUERY, 14'd16383, 14'd16383, 6'd0, 6'd0,
			16'sh0, 16'sh0, 16'sh0, 16'sh0, 1'b0},
		'{1'b0, KIND_QUERY, 14'd16383, 14'd16128, 6'd0, 6'd0,
			16'sh0, 16'sh0, 16'sh0, 16'sh0, 1'b0},
		'{1'b1, KIND_QUERY, 14'd15872, 14'd15872, 6'd0, 6'd0,
			16'sh0, 16'sh0, 16'sh0001, 16'shFFFF, 1'b0},
		// a cell no query reads
		'{1'b0, KIND_WRITE, 14'd0, 14'd0, 6'd0, 6'd0,
			16'sh0, 16'sh0, 16'sh0, 16'sh0, 1'b0},
		'{1'b0, KIND_QUERY, 14'd0, 14'd511, 6'd0, 6'd0,
			16'sh0, 16'sh0, 16'sh0, 16'sh0, 1'b0}
	};

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    kind;
	logic [POS_W-1:0]        pos_x;
	logic [POS_W-1:0]        pos_y;
	logic [CELL_W-1:0]       cell_col;
	logic [CELL_W-1:0]       cell_row;
	logic signed [G_W-1:0]   cell_vx;
	logic signed [G_W-1:0]   cell_vy;
	logic                    cfg_we;
	logic                    cfg_idx;
	logic [CFG_W-1:0]        cfg_wdata;
	logic                    done;
	logic signed [G_W-1:0]   field_x;
	logic signed [G_W-1:0]   field_y;
	logic                    clipped;

	bilinear_vector_field_sample_top dut (.*);

	// Shadow of the grid and the size registers, updated as beats are taken.
	logic signed [G_W-1:0]   cell_vx_mem [MAX_ROWS][MAX_COLS];
	logic signed [G_W-1:0]   cell_vy_mem [MAX_ROWS][MAX_COLS];
	bit                      cell_written [MAX_ROWS][MAX_COLS];
	logic [CFG_W-1:0]        cols_reg;
	logic [CFG_W-1:0]        rows_reg;

	sample_t                 expected_samples [$];
	sample_t                 want;
	int                      errors;
	int                      quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// Size registers are saturated to the legal range before use.
	function automatic int unsigned dim_in_use(input logic [CFG_W-1:0] v,
			input int unsigned hi);
		if (v < MIN_DIM)
			return MIN_DIM;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Floor of the position, clamped to 1 .. n-2 so the 2 x 2 patch stays inside the grid.
	function automatic int unsigned base_cell(input logic [POS_W-1:0] p,
			input int unsigned n);
		int unsigned c;
		c = p >> FRAC_BITS;
		if (c < 1)
			c = 1;
		if (c > n - 2)
			c = n - 2;
		return c;
	endfunction

	// Lerp both rows along x, then along y, all exact; floor at the end.
	function automatic longint blend(input longint g00, g10, g01, g11, tx, ty);
		longint one;
		longint top;
		longint bot;
		one = longint'(1) << FRAC_BITS;
		top = g00 * one + (g10 - g00) * tx;
		bot = g01 * one + (g11 - g01) * tx;
		return (top * one + (bot - top) * ty) >>> (2 * FRAC_BITS);
	endfunction

	function automatic logic signed [G_W-1:0] saturate16(input longint v,
			inout bit sat);
		if (v > SAT_MAX) begin
			sat = 1'b1;
			return G_W'(SAT_MAX);
		end
		if (v < SAT_MIN) begin
			sat = 1'b1;
			return G_W'(SAT_MIN);
		end
		return G_W'(v);
	endfunction

	function automatic sample_t predict_sample(input logic [POS_W-1:0] px,
			input logic [POS_W-1:0] py);
		int unsigned bx;
		int unsigned by;
		longint tx;
		longint ty;
		longint vx;
		longint vy;
		bit sat;
		sample_t s;
		bx = base_cell(px, dim_in_use(cols_reg, MAX_COLS));
		by = base_cell(py, dim_in_use(rows_reg, MAX_ROWS));
		// offsets go negative or past one cell when the base was clamped
		tx = longint'(px) - longint'(bx << FRAC_BITS);
		ty = longint'(py) - longint'(by << FRAC_BITS);
		vx = blend(cell_vx_mem[by][bx], cell_vx_mem[by][bx + 1],
			cell_vx_mem[by + 1][bx], cell_vx_mem[by + 1][bx + 1], tx, ty);
		vy = blend(cell_vy_mem[by][bx], cell_vy_mem[by][bx + 1],
			cell_vy_mem[by + 1][bx], cell_vy_mem[by + 1][bx + 1], tx, ty);
		sat = 1'b0;
		s.fx = saturate16(vx, sat);
		s.fy = saturate16(vy, sat);
		s.clip = sat;
		return s;
	endfunction

	// Lean on the extremes, zero and small values around zero.
	function automatic logic signed [G_W-1:0] random_component();
		case ($urandom_range(0, 7))
		0: begin
			return G_W'(SAT_MAX);
		end
		1: begin
			return G_W'(SAT_MIN);
		end
		2: begin
			return '0;
		end
		3: begin
			return G_W'(int'($urandom_range(0, 16)) - 8);
		end
		default: begin
			return G_W'($urandom);
		end
		endcase
	endfunction

	// Mostly inside the grid in use; sometimes anywhere, which extrapolates.
	function automatic logic [POS_W-1:0] query_coord(input int unsigned n);
		case ($urandom_range(0, 9))
		0: begin
			return POS_W'($urandom);
		end
		1: begin
			case ($urandom_range(0, 2))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			default: begin
				return POS_W'((n - 1) << FRAC_BITS);
			end
			endcase
		end
		default: begin
			return POS_W'($urandom_range(0, (n << FRAC_BITS) - 1));
		end
		endcase
	endfunction

	// Drive one beat and hold it until taken. Start is left high: the caller
	// either drives the next beat in the same step or drops start.
	task automatic send_beat(input beat_t b, input bit known, input sample_t lit);
		start    <= 1'b1;
		kind     <= b.kind;
		pos_x    <= b.px;
		pos_y    <= b.py;
		cell_col <= b.col;
		cell_row <= b.row;
		cell_vx  <= b.vx;
		cell_vy  <= b.vy;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		if (b.kind == KIND_WRITE) begin
			cell_vx_mem[b.row][b.col]  = b.vx;
			cell_vy_mem[b.row][b.col]  = b.vy;
			cell_written[b.row][b.col] = 1'b1;
		end else begin
			expected_samples.push_back(known ? lit : predict_sample(b.px, b.py));
		end
	endtask

	task automatic idle_burst(input bit idle_on);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 17))
				@(posedge clk);
		end
	endtask

	// Drop start, wait out every pending sample, then let the block settle.
	task automatic wait_drain();
		start <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic set_grid_size(input logic [CFG_W-1:0] c, input logic [CFG_W-1:0] r);
		wait_drain();
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_GRID_COLS;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_idx   <= REG_GRID_ROWS;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cols_reg = c;
		rows_reg = r;
	endtask

	// Random traffic: a quarter noise writes anywhere, the rest queries.
	// Before a query, fill any corner of its patch that was never written.
	task automatic run_random_phase(input int beats, input bit idle_on);
		int sent;
		int unsigned ncols;
		int unsigned nrows;
		int unsigned bx;
		int unsigned by;
		beat_t b;
		beat_t fill;
		sent = 0;
		ncols = dim_in_use(cols_reg, MAX_COLS);
		nrows = dim_in_use(rows_reg, MAX_ROWS);
		while (sent < beats) begin
			b.px  = POS_W'($urandom);
			b.py  = POS_W'($urandom);
			b.col = CELL_W'($urandom);
			b.row = CELL_W'($urandom);
			b.vx  = random_component();
			b.vy  = random_component();
			if ($urandom_range(0, 3) == 0) begin
				b.kind = KIND_WRITE;
				send_beat(b, 1'b0, '0);
				sent++;
			end else begin
				b.kind = KIND_QUERY;
				b.px = query_coord(ncols);
				b.py = query_coord(nrows);
				bx = base_cell(b.px, ncols);
				by = base_cell(b.py, nrows);
				for (int dr = 0; dr < 2; dr++) begin
					for (int dc = 0; dc < 2; dc++) begin
						if (!cell_written[by + dr][bx + dc]) begin
							fill      = b;
							fill.kind = KIND_WRITE;
							fill.col  = CELL_W'(bx + dc);
							fill.row  = CELL_W'(by + dr);
							fill.vx   = random_component();
							fill.vy   = random_component();
							send_beat(fill, 1'b0, '0);
							sent++;
							idle_burst(idle_on);
						end
					end
				end
				send_beat(b, 1'b0, '0);
				sent++;
			end
			// now and then hold off until the block has gone quiet
			if (idle_on && $urandom_range(0, 99) == 0)
				wait_drain();
			idle_burst(idle_on);
		end
	endtask

	// Every sample must match the oldest pending prediction, field by field.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (expected_samples.size() == 0) begin
				report_mismatch($sformatf("sample with no query pending: x=%0d y=%0d",
					field_x, field_y));
			end else begin
				want = expected_samples.pop_front();
				if (field_x !== want.fx)
					report_mismatch($sformatf("field_x got %0d expected %0d",
						field_x, want.fx));
				if (field_y !== want.fy)
					report_mismatch($sformatf("field_y got %0d expected %0d",
						field_y, want.fy));
				if (clipped !== want.clip)
					report_mismatch($sformatf("clipped got %b expected %b",
						clipped, want.clip));
			end
		end
	end

	// Stop a hung run: count cycles with no beat taken and no sample shown.
	always @(posedge clk) begin
		if (!arst_n || (start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[%0t] no progress for %0d cycles", $time, QUIET_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		int cols_set;
		int rows_set;
		beat_t b;
		sample_t s;
		arst_n    = 1'b0;
		start     = 1'b0;
		kind      = KIND_QUERY;
		pos_x     = '0;
		pos_y     = '0;
		cell_col  = '0;
		cell_row  = '0;
		cell_vx   = '0;
		cell_vy   = '0;
		cfg_we    = 1'b0;
		cfg_idx   = REG_GRID_COLS;
		cfg_wdata = '0;
		cols_reg  = CFG_W'(MAX_COLS);
		rows_reg  = CFG_W'(MAX_ROWS);
		errors    = 0;
		quiet_cycles = 0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;

		// Directed part, under the reset grid size.
		for (int i = 0; i < DIR_ROWS; i++) begin
			b = '{DIRECTED[i].kind, DIRECTED[i].px, DIRECTED[i].py, DIRECTED[i].col,
				DIRECTED[i].row, DIRECTED[i].vx, DIRECTED[i].vy};
			s = '{DIRECTED[i].fx, DIRECTED[i].fy, DIRECTED[i].clip};
			send_beat(b, DIRECTED[i].known, s);
			idle_burst(1'b1);
		end

		// Random phases over several grid sizes, out-of-range values included;
		// the last phase runs back to back with no idling.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
			0: begin
				cols_set = MAX_COLS;
				rows_set = MAX_ROWS;
			end
			1: begin
				cols_set = MIN_DIM;
				rows_set = MIN_DIM;
			end
			2: begin
				cols_set = 0;
				rows_set = 127;
			end
			3: begin
				cols_set = 127;
				rows_set = 2;
			end
			4: begin
				cols_set = 1;
				rows_set = 65;
			end
			5: begin
				cols_set = $urandom_range(MIN_DIM, MAX_COLS);
				rows_set = $urandom_range(MIN_DIM, MAX_ROWS);
			end
			6: begin
				cols_set = $urandom_range(0, 127);
				rows_set = $urandom_range(0, 127);
			end
			default: begin
				cols_set = MAX_COLS;
				rows_set = MAX_ROWS;
			end
			endcase
			set_grid_size(CFG_W'(cols_set), CFG_W'(rows_set));
			run_random_phase(PHASE_BEATS, ph != PHASES - 1);
		end

		wait_drain();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
